// File: hw/rtl/sirc_pkg.sv
// Shared constants and types for the signed integer to radix text converter.
// Used by every module of the block; depends on nothing else.
package sirc_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int MAX_RADIX   = 16;
  localparam int RADIX_W     = 5;
  localparam int DIGIT_W     = 4;
  localparam int CHAR_W      = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int NUM_DIGITS  = VALUE_BITS;
  localparam int DIG_IDX_W   = $clog2(NUM_DIGITS);
  localparam int DIG_CNT_W   = $clog2(NUM_DIGITS + 1);
  localparam int BIT_CNT_W   = $clog2(VALUE_BITS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HIGH = 2'd2;

  typedef logic [CHAR_W-1:0] char_t;

  typedef struct packed {
    logic [RADIX_W-1:0]           len;
    char_t [MAX_RADIX-1:0]        alpha;
  } cfg_t;

  typedef struct packed {
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
  } item_t;

endpackage

// File: hw/rtl/sirc_front.sv
// Front end: checks the configured alphabet and splits each request into sign and magnitude.
// Depends on sirc_pkg.
module sirc_front import sirc_pkg::*; (
  input  cfg_t                          cfg_i,
  input  logic                          push_i,
  input  logic signed [VALUE_BITS-1:0]  value_i,
  input  logic                          q_full_i,
  output logic                          full_o,
  output logic                          q_wr_o,
  output item_t                         q_item_o
);

  logic                  alpha_ok;
  logic [VALUE_BITS-1:0] raw;

  always_comb begin
    alpha_ok = (cfg_i.len >= RADIX_W'(2)) && (cfg_i.len <= RADIX_W'(MAX_RADIX));
    for (int i = 0; i < MAX_RADIX; i++) begin
      if (RADIX_W'(i) < cfg_i.len) begin
        if (cfg_i.alpha[i] == CHAR_W'(0) || cfg_i.alpha[i] == CH_PLUS ||
            cfg_i.alpha[i] == CH_MINUS) begin
          alpha_ok = 1'b0;
        end
        for (int j = i + 1; j < MAX_RADIX; j++) begin
          if (RADIX_W'(j) < cfg_i.len && cfg_i.alpha[j] == cfg_i.alpha[i]) begin
            alpha_ok = 1'b0;
          end
        end
      end
    end
  end

  assign raw           = value_i;
  assign q_item_o.neg  = raw[VALUE_BITS-1];
  assign q_item_o.mag  = raw[VALUE_BITS-1] ? (VALUE_BITS'(0) - raw) : raw;
  assign full_o        = q_full_i;
  assign q_wr_o        = push_i && !q_full_i && alpha_ok;

endmodule

// File: hw/rtl/sirc_fifo.sv
// Short queue of classified requests between the front end and the converter.
// Depends on sirc_pkg.
module sirc_fifo import sirc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_i,
  input  item_t wdata_i,
  output logic  full_o,
  input  logic  rd_i,
  output item_t rdata_o,
  output logic  empty_o
);

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              do_wr, do_rd;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
    end
    if (do_rd) begin
      rptr_d = (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + (QPTR_W+1)'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// File: hw/rtl/sirc_back.sv
// Back end: bit-serial conversion of the magnitude into radix digits, then character output.
// Depends on sirc_pkg.
module sirc_back import sirc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        q_empty_i,
  input  item_t       q_item_i,
  output logic        q_rd_o,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [CHAR_W-1:0] out_char_o,
  output logic        last_char_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  localparam int SUM_W = NUM_DIGITS + 1;

  state_e                state_q, state_d;
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic                  sign_q, sign_d;
  logic [DIG_CNT_W-1:0]  cnt_q, cnt_d;
  logic [BIT_CNT_W-1:0]  bit_q, bit_d;
  logic [DIG_IDX_W-1:0]  idx_q, idx_d;
  logic                  out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]     out_char_q, out_char_d;
  logic                  out_last_q, out_last_d;
  logic [DIGIT_W-1:0]    dig_q [NUM_DIGITS];
  logic [DIGIT_W-1:0]    dig_next [NUM_DIGITS];
  logic                  clear, shift, slot_free;

  logic [RADIX_W-1:0]    radix;
  logic [NUM_DIGITS-1:0] gen, prop;
  logic [SUM_W-1:0]      sum;
  logic [NUM_DIGITS:0]   carry;
  logic [RADIX_W-1:0]    twice;

  assign radix = cfg_i.len;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      gen[i]  = ({dig_q[i], 1'b0} >= radix);
      prop[i] = ({dig_q[i], 1'b1} == radix);
    end
    sum = {1'b0, gen | prop} + {1'b0, gen} + SUM_W'(mag_q[VALUE_BITS-1]);
    for (int i = 0; i < NUM_DIGITS; i++) begin
      carry[i] = sum[i] ^ prop[i];
    end
    carry[NUM_DIGITS] = sum[SUM_W-1];
  end

  always_comb begin
    twice = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      twice       = {dig_q[i], carry[i]};
      dig_next[i] = carry[i+1] ? DIGIT_W'(twice - radix) : DIGIT_W'(twice);
    end
  end

  assign slot_free = !out_valid_q || pop_i;

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    sign_d      = sign_q;
    cnt_d       = cnt_q;
    bit_d       = bit_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !pop_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    q_rd_o      = 1'b0;
    clear       = 1'b0;
    shift       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_rd_o  = 1'b1;
          clear   = 1'b1;
          mag_d   = q_item_i.mag;
          sign_d  = q_item_i.neg;
          cnt_d   = '0;
          bit_d   = '0;
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        shift = 1'b1;
        mag_d = {mag_q[VALUE_BITS-2:0], 1'b0};
        cnt_d = cnt_q + DIG_CNT_W'(carry[cnt_q]);
        bit_d = bit_q + BIT_CNT_W'(1);
        if (bit_q == BIT_CNT_W'(VALUE_BITS - 1)) begin
          idx_d   = (cnt_d == '0) ? '0 : DIG_IDX_W'(cnt_d - DIG_CNT_W'(1));
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          if (sign_q) begin
            out_char_d = CH_MINUS;
            out_last_d = 1'b0;
            sign_d     = 1'b0;
          end else begin
            out_char_d = cfg_i.alpha[dig_q[idx_q]];
            out_last_d = (idx_q == '0);
            if (idx_q == '0) begin
              state_d = ST_IDLE;
            end else begin
              idx_d = idx_q - DIG_IDX_W'(1);
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mag_q       <= '0;
      sign_q      <= 1'b0;
      cnt_q       <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mag_q       <= mag_d;
      sign_q      <= sign_d;
      cnt_q       <= cnt_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (clear) begin
        dig_q[i] <= '0;
      end else if (shift) begin
        dig_q[i] <= dig_next[i];
      end
    end
  end

  assign empty_o     = !out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_char_o = out_last_q;

endmodule

// File: hw/rtl/signed_int_to_custom_radix_chars.sv
// Top level of the signed integer to radix text converter: configuration registers and wiring.
// Depends on sirc_pkg, sirc_front, sirc_fifo and sirc_back.
//
// Usage: a signed value is pushed with push while full is low. The text comes out one
// character per request on out_char_o, read with pop while empty is low; last_char_o
// marks the final character of a value. A negative value starts with '-'.
// The radix and digit alphabet are set through cfg_we_i, cfg_idx_i and cfg_wdata_i;
// the user must do so only while no value is in flight; the block does not enforce this.
// With an invalid alphabet a value yields no text. The converter takes a value from
// the two-entry queue, shifts its 32 magnitude bits into the digit row, then issues
// one character per cycle while the receiver does not stall. It works on one value at
// a time: the back end takes the next value only after the last character is issued,
// as its bit-serial digit row holds the digits of a single value.
// Reset empties the queue and the output, and restores decimal digits "0123456789".
// When the receiver stalls, the current character holds, the back end waits, and the
// queue takes up to two more values before full rises.
module signed_int_to_custom_radix_chars import sirc_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic signed [VALUE_BITS-1:0] value_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [CHAR_W-1:0]            out_char_o,
  output logic                         last_char_o,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata_i
);

  logic [RADIX_W-1:0]    len_q;
  logic [CFG_DATA_W-1:0] alpha_low_q, alpha_high_q;
  cfg_t                  cfg;
  logic                  q_full, q_empty, q_wr, q_rd;
  item_t                 q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q        <= RADIX_W'(10);
      alpha_low_q  <= 64'h3736353433323130;
      alpha_high_q <= 64'h0000000000003938;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ALPHA_LEN:  len_q        <= cfg_wdata_i[RADIX_W-1:0];
        CFG_ALPHA_LOW:  alpha_low_q  <= cfg_wdata_i;
        CFG_ALPHA_HIGH: alpha_high_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign cfg.len   = len_q;
  assign cfg.alpha = {alpha_high_q, alpha_low_q};

  sirc_front u_front (
    .cfg_i    (cfg),
    .push_i   (push),
    .value_i  (value_i),
    .q_full_i (q_full),
    .full_o   (full),
    .q_wr_o   (q_wr),
    .q_item_o (q_wdata)
  );

  sirc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  sirc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_empty_i   (q_empty),
    .q_item_i    (q_rdata),
    .q_rd_o      (q_rd),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

endmodule

// File: hw/rtl/sirc_checker.sv
// Port-level checks of the radix text converter, attached to the top level by bind.
// Depends on sirc_pkg and signed_int_to_custom_radix_chars.
module sirc_checker import sirc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              empty,
  input logic              pop,
  input logic [CHAR_W-1:0] out_char_o,
  input logic              last_char_o
);

  a_empty_in_reset: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("Result shown during reset.");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_char_o) && $stable(last_char_o)))
    else $error("Stalled result changed.");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_char_o == CH_MINUS) |-> !last_char_o)
    else $error("Minus sign flagged as final character.");

  a_char_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_char_o != CHAR_W'(0)))
    else $error("Zero character shown.");

endmodule

bind signed_int_to_custom_radix_chars sirc_checker u_sirc_checker (.*);
